[rtl/core/eprs_pkg.sv]
// Shared constants, codes and types of the elite pool roulette selector.
package eprs_pkg;

    // Pool geometry.
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths fixed by the item format.
    localparam int OP_W   = 2;
    localparam int FIT_W  = 16;
    localparam int TAG_W  = 16;
    localparam int AGE_W  = 16;
    localparam int CAP_W  = 5;
    localparam int RND_W  = 16;
    localparam int Q16_W  = 16;

    // Arithmetic widths: one weight, the sum of all weights, the shared product.
    localparam int WEIGHT_W = 2 * FIT_W + 1;
    localparam int TOT_W    = WEIGHT_W + IDX_W;
    localparam int PROD_W   = Q16_W + TOT_W;

    // Stream payload widths.
    localparam int S_DATA_W = 72;
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = 56;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Fixed-point constants: weight floor 0.01 in Q16.16, default decay 0.995 in Q0.16.
    localparam logic [WEIGHT_W-1:0] FLOOR_WEIGHT  = WEIGHT_W'(655);
    localparam logic [Q16_W-1:0]    DEFAULT_DECAY = 16'd65208;
    localparam logic [AGE_W-1:0]    AGE_MAX       = '1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_DECAY  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_CAPACITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURVIVAL_BIAS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EVOLUTION_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ELITE_FRACTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR   = 3'd4;

    typedef logic [FIT_W-1:0] fit_t;
    typedef logic [TAG_W-1:0] tag_t;
    typedef logic [AGE_W-1:0] age_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

endpackage

[rtl/core/elite_pool_roulette_select.sv]
// Top level of the elite pool roulette selector: sorted pool, sequencer and shared multiplier.
//
// Input items arrive on the s_ stream: s_tuser carries the operation (insert, pick,
// decay tick, no operation) and s_tdata the insert and draw fields. Every item gives
// exactly one result item on the m_ stream. Registers are written through cfg_wr_en,
// cfg_index and cfg_wdata; the user must write them only while the block is idle, and
// the block itself does not enforce it. One item is worked on at a time; s_tready is
// high only while the sequencer idles. All multiplications go through one 16 x 37 bit
// multiplier with a registered product, fed one pool slot per cycle. An insert moves
// one slot down per cycle; a pick makes one pass that sums the weights of the n entries
// in the draw and a second pass that walks them; a decay scales and ages each held
// entry; no operation and a pick on an empty pool go straight to the result.
// A finished result waits in its state until the output register is free, so a
// stalled receiver holds the block after at most one further item.
// Reset empties the pool and loads the register defaults; slot contents are not
// cleared and are never read before an insert writes them.
module elite_pool_roulette_select (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Fields from bit 0 up: fitness_in, tag_in, capacity_override, pick_random,
    // elite_random, zero fill.
    input  logic [eprs_pkg::S_DATA_W-1:0]    s_tdata,
    // Fields from bit 0 up: operation.
    input  logic [eprs_pkg::S_USER_W-1:0]    s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0 up: picked_tag, picked_fitness, picked_age, pool_empty,
    // drawn_from_elite, insert_kept, pool_count.
    output logic [eprs_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_wr_en,
    input  logic [eprs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eprs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INS   = 4'd1;
    localparam logic [3:0] ST_ELITE = 4'd2;
    localparam logic [3:0] ST_NSEL  = 4'd3;
    localparam logic [3:0] ST_SUM   = 4'd4;
    localparam logic [3:0] ST_POINT = 4'd5;
    localparam logic [3:0] ST_PWAIT = 4'd6;
    localparam logic [3:0] ST_WALK  = 4'd7;
    localparam logic [3:0] ST_DECAY = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam eprs_pkg::cnt_t CNT_MAX = eprs_pkg::CNT_W'(eprs_pkg::MAX_ENTRIES);

    // Pool slots.
    eprs_pkg::fit_t slot_fitness [eprs_pkg::MAX_ENTRIES];
    eprs_pkg::tag_t slot_tag     [eprs_pkg::MAX_ENTRIES];
    eprs_pkg::age_t slot_age     [eprs_pkg::MAX_ENTRIES];

    // Control registers.
    logic [3:0]                  state_reg, state_next;
    eprs_pkg::cnt_t              held_reg, held_next;
    logic [eprs_pkg::CAP_W-1:0]  pool_capacity_reg, pool_capacity_next;
    logic [eprs_pkg::Q16_W-1:0]  survival_bias_reg, survival_bias_next;
    logic                        evolution_mode_reg, evolution_mode_next;
    logic [eprs_pkg::Q16_W-1:0]  elite_fraction_reg, elite_fraction_next;
    logic [eprs_pkg::Q16_W-1:0]  decay_factor_reg, decay_factor_next;
    logic                        prod_vld_reg, prod_vld_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    // Datapath registers.
    logic [eprs_pkg::OP_W-1:0]   op_reg, op_next;
    eprs_pkg::fit_t              fit_in_reg, fit_in_next;
    eprs_pkg::tag_t              tag_in_reg, tag_in_next;
    logic [eprs_pkg::CAP_W-1:0]  ovr_reg, ovr_next;
    logic [eprs_pkg::RND_W-1:0]  prnd_reg, prnd_next;
    logic [eprs_pkg::RND_W-1:0]  ernd_reg, ernd_next;
    eprs_pkg::cnt_t              ins_idx_reg, ins_idx_next;
    eprs_pkg::cnt_t              issue_idx_reg, issue_idx_next;
    eprs_pkg::cnt_t              n_reg, n_next;
    logic [eprs_pkg::PROD_W-1:0] prod_reg, prod_next;
    eprs_pkg::idx_t              prod_idx_reg, prod_idx_next;
    logic [eprs_pkg::TOT_W-1:0]  total_reg, total_next;
    logic [eprs_pkg::TOT_W-1:0]  point_reg, point_next;
    eprs_pkg::idx_t              k_reg, k_next;
    logic                        res_hit_reg, res_hit_next;
    logic                        res_empty_reg, res_empty_next;
    logic                        res_elite_reg, res_elite_next;
    logic                        res_kept_reg, res_kept_next;
    logic [eprs_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Shared multiplier operands.
    logic [eprs_pkg::Q16_W-1:0]  mul_a;
    logic [eprs_pkg::TOT_W-1:0]  mul_b;

    // Slot read ports and write strobes.
    eprs_pkg::idx_t  fit_rd_idx, age_rd_idx, tag_rd_idx, ins_m1;
    eprs_pkg::fit_t  fit_rd;
    eprs_pkg::age_t  age_rd;
    eprs_pkg::tag_t  tag_rd;
    logic            fit_we, tag_we, age_we;
    eprs_pkg::idx_t  wr_idx;
    eprs_pkg::fit_t  wr_fit;
    eprs_pkg::tag_t  wr_tag;
    eprs_pkg::age_t  wr_age;

    // Helper values.
    logic                          issuing;
    logic [eprs_pkg::WEIGHT_W-1:0] weight;
    logic [eprs_pkg::CAP_W-1:0]    cap_sel;
    eprs_pkg::cnt_t                cap_lim, held_ins, held_fin, elite_cnt;
    logic                          shift_go;
    logic [eprs_pkg::Q16_W-1:0]    decay_sel;

    assign ins_m1 = eprs_pkg::IDX_W'(ins_idx_reg - eprs_pkg::CNT_W'(1));

    // Read address selection, one address per slot array.
    always_comb begin
        unique case (state_reg)
            ST_INS: begin
                fit_rd_idx = ins_m1;
                age_rd_idx = ins_m1;
                tag_rd_idx = ins_m1;
            end
            ST_OUT: begin
                fit_rd_idx = k_reg;
                age_rd_idx = k_reg;
                tag_rd_idx = k_reg;
            end
            ST_DECAY: begin
                fit_rd_idx = issue_idx_reg[eprs_pkg::IDX_W-1:0];
                age_rd_idx = prod_idx_reg;
                tag_rd_idx = k_reg;
            end
            default: begin
                fit_rd_idx = issue_idx_reg[eprs_pkg::IDX_W-1:0];
                age_rd_idx = k_reg;
                tag_rd_idx = k_reg;
            end
        endcase
    end

    assign fit_rd = slot_fitness[fit_rd_idx];
    assign age_rd = slot_age[age_rd_idx];
    assign tag_rd = slot_tag[tag_rd_idx];

    // Weight of the slot whose product is in the product register.
    assign weight = eprs_pkg::WEIGHT_W'(prod_reg[2*eprs_pkg::FIT_W-1:0]) + eprs_pkg::FLOOR_WEIGHT;

    // Capacity for the current insert.
    assign cap_sel  = (ovr_reg != '0) ? ovr_reg : pool_capacity_reg;
    assign cap_lim  = (int'(cap_sel) > eprs_pkg::MAX_ENTRIES) ? CNT_MAX
                                                             : eprs_pkg::CNT_W'(cap_sel);
    assign held_ins = (held_reg < CNT_MAX) ? held_reg + eprs_pkg::CNT_W'(1) : held_reg;
    assign held_fin = (held_ins > cap_lim) ? cap_lim : held_ins;
    assign shift_go = (ins_idx_reg != '0) && (fit_rd < fit_in_reg);

    assign elite_cnt = prod_reg[eprs_pkg::Q16_W +: eprs_pkg::CNT_W];
    assign decay_sel = evolution_mode_reg ? decay_factor_reg : eprs_pkg::DEFAULT_DECAY;

    // Sequencer and datapath next state.
    always_comb begin
        state_next          = state_reg;
        held_next           = held_reg;
        pool_capacity_next  = pool_capacity_reg;
        survival_bias_next  = survival_bias_reg;
        evolution_mode_next = evolution_mode_reg;
        elite_fraction_next = elite_fraction_reg;
        decay_factor_next   = decay_factor_reg;
        m_tvalid_next       = m_tvalid_reg;
        m_tdata_next        = m_tdata_reg;
        op_next             = op_reg;
        fit_in_next         = fit_in_reg;
        tag_in_next         = tag_in_reg;
        ovr_next            = ovr_reg;
        prnd_next           = prnd_reg;
        ernd_next           = ernd_reg;
        ins_idx_next        = ins_idx_reg;
        issue_idx_next      = issue_idx_reg;
        n_next              = n_reg;
        total_next          = total_reg;
        point_next          = point_reg;
        k_next              = k_reg;
        res_hit_next        = res_hit_reg;
        res_empty_next      = res_empty_reg;
        res_elite_next      = res_elite_reg;
        res_kept_next       = res_kept_reg;
        prod_vld_next       = 1'b0;
        prod_idx_next       = issue_idx_reg[eprs_pkg::IDX_W-1:0];
        issuing             = 1'b0;
        mul_a               = fit_rd;
        mul_b               = eprs_pkg::TOT_W'(survival_bias_reg);
        fit_we              = 1'b0;
        tag_we              = 1'b0;
        age_we              = 1'b0;
        wr_idx              = ins_idx_reg[eprs_pkg::IDX_W-1:0];
        wr_fit              = fit_rd;
        wr_tag              = tag_rd;
        wr_age              = age_rd;

        // Configuration writes; indexes past the list are ignored.
        if (cfg_wr_en) begin
            unique case (cfg_index)
                eprs_pkg::CFG_POOL_CAPACITY:
                    pool_capacity_next = cfg_wdata[eprs_pkg::CAP_W-1:0];
                eprs_pkg::CFG_SURVIVAL_BIAS:  survival_bias_next  = cfg_wdata;
                eprs_pkg::CFG_EVOLUTION_MODE: evolution_mode_next = cfg_wdata[0];
                eprs_pkg::CFG_ELITE_FRACTION: elite_fraction_next = cfg_wdata;
                eprs_pkg::CFG_DECAY_FACTOR:   decay_factor_next   = cfg_wdata;
                default: ;
            endcase
        end

        // The output register empties when the receiver takes the item.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next        = s_tuser;
                    fit_in_next    = s_tdata[15:0];
                    tag_in_next    = s_tdata[31:16];
                    ovr_next       = s_tdata[36:32];
                    prnd_next      = s_tdata[52:37];
                    ernd_next      = s_tdata[68:53];
                    res_hit_next   = 1'b0;
                    res_empty_next = 1'b0;
                    res_elite_next = 1'b0;
                    res_kept_next  = 1'b0;
                    ins_idx_next   = held_reg;
                    issue_idx_next = '0;
                    unique case (s_tuser)
                        eprs_pkg::OP_INSERT: state_next = ST_INS;
                        eprs_pkg::OP_PICK: begin
                            if (held_reg == '0) begin
                                res_empty_next = 1'b1;
                                state_next     = ST_OUT;
                            end else begin
                                state_next = ST_ELITE;
                            end
                        end
                        eprs_pkg::OP_DECAY: state_next = ST_DECAY;
                        default:            state_next = ST_OUT;
                    endcase
                end
            end

            // Walk up from the bottom, moving each lower-fitness entry down one slot.
            ST_INS: begin
                if (shift_go) begin
                    if (ins_idx_reg < CNT_MAX) begin
                        fit_we = 1'b1;
                        tag_we = 1'b1;
                        age_we = 1'b1;
                    end
                    ins_idx_next = ins_idx_reg - eprs_pkg::CNT_W'(1);
                end else begin
                    if (ins_idx_reg < CNT_MAX) begin
                        fit_we    = 1'b1;
                        tag_we    = 1'b1;
                        age_we    = 1'b1;
                        wr_fit    = fit_in_reg;
                        wr_tag    = tag_in_reg;
                        wr_age    = '0;
                    end
                    held_next     = held_fin;
                    res_kept_next = (ins_idx_reg < held_fin);
                    state_next    = ST_OUT;
                end
            end

            // Elite prefix size: held count times the elite fraction.
            ST_ELITE: begin
                mul_a      = elite_fraction_reg;
                mul_b      = eprs_pkg::TOT_W'(held_reg);
                state_next = ST_NSEL;
            end

            ST_NSEL: begin
                if (evolution_mode_reg && (ernd_reg < elite_fraction_reg)) begin
                    n_next         = (elite_cnt == '0) ? eprs_pkg::CNT_W'(1) : elite_cnt;
                    res_elite_next = 1'b1;
                end else begin
                    n_next = held_reg;
                end
                issue_idx_next = '0;
                total_next     = '0;
                state_next     = ST_SUM;
            end

            // First pass: sum the weights of the first n entries.
            ST_SUM: begin
                issuing = (issue_idx_reg < n_reg);
                if (issuing) begin
                    issue_idx_next = issue_idx_reg + eprs_pkg::CNT_W'(1);
                end
                prod_vld_next = issuing;
                if (prod_vld_reg) begin
                    total_next = total_reg + eprs_pkg::TOT_W'(weight);
                end
                if (!issuing && !prod_vld_reg) begin
                    state_next = ST_POINT;
                end
            end

            // Roulette point: draw times total, scaled down by the Q0.16 step.
            ST_POINT: begin
                mul_a      = prnd_reg;
                mul_b      = total_reg;
                state_next = ST_PWAIT;
            end

            ST_PWAIT: begin
                point_next     = prod_reg[eprs_pkg::PROD_W-1:eprs_pkg::Q16_W];
                issue_idx_next = '0;
                state_next     = ST_WALK;
            end

            // Second pass: subtract weights until the point lands in one.
            ST_WALK: begin
                if (prod_vld_reg && (point_reg <= eprs_pkg::TOT_W'(weight))) begin
                    k_next       = prod_idx_reg;
                    res_hit_next = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    issuing = (issue_idx_reg < n_reg);
                    if (issuing) begin
                        issue_idx_next = issue_idx_reg + eprs_pkg::CNT_W'(1);
                    end
                    prod_vld_next = issuing;
                    if (prod_vld_reg) begin
                        point_next = point_reg - eprs_pkg::TOT_W'(weight);
                    end
                    if (!issuing && !prod_vld_reg) begin
                        k_next       = '0;
                        res_hit_next = 1'b1;
                        state_next   = ST_OUT;
                    end
                end
            end

            // Scale each held fitness and age the entry, one slot per cycle.
            ST_DECAY: begin
                mul_b   = eprs_pkg::TOT_W'(decay_sel);
                issuing = (issue_idx_reg < held_reg);
                if (issuing) begin
                    issue_idx_next = issue_idx_reg + eprs_pkg::CNT_W'(1);
                end
                prod_vld_next = issuing;
                if (prod_vld_reg) begin
                    fit_we = 1'b1;
                    age_we = 1'b1;
                    wr_idx = prod_idx_reg;
                    wr_fit = prod_reg[2*eprs_pkg::FIT_W-1:eprs_pkg::FIT_W];
                    wr_age = (age_rd != eprs_pkg::AGE_MAX) ? age_rd + eprs_pkg::AGE_W'(1)
                                                            : age_rd;
                end
                if (!issuing && !prod_vld_reg) begin
                    state_next = ST_OUT;
                end
            end

            // Load the result into the output register once it is free.
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {held_reg, res_kept_reg, res_elite_reg, res_empty_reg,
                                     res_hit_reg ? age_rd : eprs_pkg::AGE_W'(0),
                                     res_hit_reg ? fit_rd : eprs_pkg::FIT_W'(0),
                                     res_hit_reg ? tag_rd : eprs_pkg::TAG_W'(0)};
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        prod_next = eprs_pkg::PROD_W'(mul_a) * eprs_pkg::PROD_W'(mul_b);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            held_reg           <= '0;
            pool_capacity_reg  <= eprs_pkg::CAP_W'(16);
            survival_bias_reg  <= 16'd256;
            evolution_mode_reg <= 1'b0;
            elite_fraction_reg <= 16'd13107;
            decay_factor_reg   <= 16'd65208;
            prod_vld_reg       <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg          <= state_next;
            held_reg           <= held_next;
            pool_capacity_reg  <= pool_capacity_next;
            survival_bias_reg  <= survival_bias_next;
            evolution_mode_reg <= evolution_mode_next;
            elite_fraction_reg <= elite_fraction_next;
            decay_factor_reg   <= decay_factor_next;
            prod_vld_reg       <= prod_vld_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        fit_in_reg    <= fit_in_next;
        tag_in_reg    <= tag_in_next;
        ovr_reg       <= ovr_next;
        prnd_reg      <= prnd_next;
        ernd_reg      <= ernd_next;
        ins_idx_reg   <= ins_idx_next;
        issue_idx_reg <= issue_idx_next;
        n_reg         <= n_next;
        prod_reg      <= prod_next;
        prod_idx_reg  <= prod_idx_next;
        total_reg     <= total_next;
        point_reg     <= point_next;
        k_reg         <= k_next;
        res_hit_reg   <= res_hit_next;
        res_empty_reg <= res_empty_next;
        res_elite_reg <= res_elite_next;
        res_kept_reg  <= res_kept_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // Slot storage, one write port per array.
    always_ff @(posedge aclk) begin
        if (fit_we) begin
            slot_fitness[wr_idx] <= wr_fit;
        end
        if (tag_we) begin
            slot_tag[wr_idx] <= wr_tag;
        end
        if (age_we) begin
            slot_age[wr_idx] <= wr_age;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The pool never holds more entries than it has slots.
    assert property (@(posedge aclk) disable iff (!aresetn) held_reg <= CNT_MAX)
        else $error("pool count above slot count");

    // An empty pick reports no entry fields and no elite draw.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[48]) |-> (m_tdata[47:0] == '0 && !m_tdata[49] && !m_tdata[50]))
        else $error("empty pick carries entry data");

    // A kept insert leaves at least one entry in the pool.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[50]) |-> (m_tdata[55:51] != '0))
        else $error("insert kept with empty pool");

    // The weight passes never issue past the draw size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM || state_reg == ST_WALK) |-> (issue_idx_reg <= n_reg))
        else $error("roulette pass ran past its range");

endmodule
